// ----- sv/srgb8_pkg.sv -----
// shared constants, codes and constant-table functions for the srgb8 pixel converter
package srgb8_pkg;

  // parameter defaults
  localparam int unsigned SRGB8_MAX_WIDTH  = 4096;
  localparam int unsigned SRGB8_MAX_HEIGHT = 4096;
  localparam int unsigned SRGB8_MAX_DEPTH  = 256;

  // field widths
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned Z_W    = 8;
  localparam int unsigned ADDR_W = 34;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;

  // command codes
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_HAS_ALPHA    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  // float32 one, output alpha without an alpha channel
  localparam logic [31:0] F32_ONE = 32'h3F80_0000;

  // per-lane control carried alongside the payload
  typedef struct packed {
    logic en;
    logic cmd;
  } lane_ctrl_t;

  // decode table for sRGB bytes
  localparam real LIN_TAB [256] = '{
    0.0, 0.000303527, 0.000607054, 0.000910581, 0.00121411, 0.00151763, 0.00182116,
    0.00212469, 0.00242822, 0.00273174, 0.00303527, 0.00334654, 0.00367651, 0.00402472,
    0.00439144, 0.00477695, 0.00518152, 0.00560539, 0.00604883, 0.00651209, 0.00699541,
    0.00749903, 0.00802319, 0.00856812, 0.00913406, 0.00972122, 0.0103298, 0.0109601,
    0.0116122, 0.0122865, 0.012983, 0.0137021, 0.0144438, 0.0152085, 0.0159963, 0.0168074,
    0.017642, 0.0185002, 0.0193824, 0.0202886, 0.021219, 0.0221739, 0.0231534, 0.0241576,
    0.0251869, 0.0262412, 0.0273209, 0.028426, 0.0295568, 0.0307134, 0.031896, 0.0331048,
    0.0343398, 0.0356013, 0.0368894, 0.0382044, 0.0395462, 0.0409152, 0.0423114, 0.043735,
    0.0451862, 0.0466651, 0.0481718, 0.0497066, 0.0512695, 0.0528607, 0.0544803, 0.0561285,
    0.0578054, 0.0595112, 0.0612461, 0.06301, 0.0648033, 0.066626, 0.0684782, 0.0703601,
    0.0722719, 0.0742136, 0.0761854, 0.0781874, 0.0802198, 0.0822827, 0.0843762, 0.0865005,
    0.0886556, 0.0908417, 0.093059, 0.0953075, 0.0975874, 0.0998987, 0.102242, 0.104616,
    0.107023, 0.109462, 0.111932, 0.114435, 0.116971, 0.119538, 0.122139, 0.124772,
    0.127438, 0.130136, 0.132868, 0.135633, 0.138432, 0.141263, 0.144128, 0.147027,
    0.14996, 0.152926, 0.155926, 0.158961, 0.162029, 0.165132, 0.168269, 0.171441,
    0.174647, 0.177888, 0.181164, 0.184475, 0.187821, 0.191202, 0.194618, 0.198069,
    0.201556, 0.205079, 0.208637, 0.212231, 0.215861, 0.219526, 0.223228, 0.226966,
    0.23074, 0.234551, 0.238398, 0.242281, 0.246201, 0.250158, 0.254152, 0.258183,
    0.262251, 0.266356, 0.270498, 0.274677, 0.278894, 0.283149, 0.287441, 0.291771,
    0.296138, 0.300544, 0.304987, 0.309469, 0.313989, 0.318547, 0.323143, 0.327778,
    0.332452, 0.337164, 0.341914, 0.346704, 0.351533, 0.3564, 0.361307, 0.366253,
    0.371238, 0.376262, 0.381326, 0.38643, 0.391573, 0.396755, 0.401978, 0.40724,
    0.412543, 0.417885, 0.423268, 0.428691, 0.434154, 0.439657, 0.445201, 0.450786,
    0.456411, 0.462077, 0.467784, 0.473532, 0.47932, 0.48515, 0.491021, 0.496933,
    0.502887, 0.508881, 0.514918, 0.520996, 0.527115, 0.533276, 0.53948, 0.545725,
    0.552011, 0.55834, 0.564712, 0.571125, 0.577581, 0.584078, 0.590619, 0.597202,
    0.603827, 0.610496, 0.617207, 0.62396, 0.630757, 0.637597, 0.64448, 0.651406,
    0.658375, 0.665387, 0.672443, 0.679543, 0.686685, 0.693872, 0.701102, 0.708376,
    0.715694, 0.723055, 0.730461, 0.737911, 0.745404, 0.752942, 0.760525, 0.768151,
    0.775822, 0.783538, 0.791298, 0.799103, 0.806952, 0.814847, 0.822786, 0.83077,
    0.838799, 0.846873, 0.854993, 0.863157, 0.871367, 0.879622, 0.887923, 0.896269,
    0.904661, 0.913099, 0.921582, 0.930111, 0.938686, 0.947307, 0.955974, 0.964686,
    0.973445, 0.982251, 0.991102, 1.0
  };

  // fifth root, elaboration only
  function automatic real srgb8_fifth_root(input real a);
    return a ** 0.2;
  endfunction

  // linear value whose exact sRGB value is (k-0.5)/255
  function automatic real srgb8_thresh(input int k);
    real s;
    real t;
    real b;
    real b2;
    s = (real'(k) - 0.5) / 255.0;
    t = s / 12.92;
    if (t >= 0.0031308) begin
      b  = (s + 0.055) / 1.055;
      b2 = b * b;
      t  = b2 * srgb8_fifth_root(b2);
    end
    return t;
  endfunction

  // positive normal real to float32 bits, rounded up or to nearest even
  function automatic logic [31:0] srgb8_f32_bits(input real t, input logic round_up);
    logic [63:0] d;
    logic [10:0] ex;
    logic [52:0] m;
    logic        inc;
    logic [31:0] r;
    d  = $realtobits(t);
    ex = d[62:52];
    m  = {1'b1, d[51:0]};
    if (round_up) begin
      inc = (m[28:0] != 29'd0);
    end else begin
      inc = m[28] && ((m[27:0] != 28'd0) || m[29]);
    end
    r = {1'b0, 8'(ex - 11'd896), m[51:29]} + {31'd0, inc};
    if (t == 0.0) begin
      r = 32'd0;
    end
    return r;
  endfunction

endpackage

// ----- sv/srgb8_in_if.sv -----
// input channel interface: one pixel item per handshake
interface srgb8_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  pos_z;
  logic [31:0] red_linear;
  logic [31:0] green_linear;
  logic [31:0] blue_linear;
  logic [31:0] alpha_linear;
  logic [7:0]  red_srgb;
  logic [7:0]  green_srgb;
  logic [7:0]  blue_srgb;
  logic [7:0]  alpha_byte;

  modport source (
    output valid, command, pos_x, pos_y, pos_z, red_linear, green_linear, blue_linear,
           alpha_linear, red_srgb, green_srgb, blue_srgb, alpha_byte,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, pos_z, red_linear, green_linear, blue_linear,
           alpha_linear, red_srgb, green_srgb, blue_srgb, alpha_byte,
    output ready
  );
endinterface

// ----- sv/srgb8_out_if.sv -----
// output channel interface: one result item per handshake
interface srgb8_out_if;
  logic        valid;
  logic        ready;
  logic [33:0] byte_address;
  logic [7:0]  red_byte_out;
  logic [7:0]  green_byte_out;
  logic [7:0]  blue_byte_out;
  logic [7:0]  alpha_byte_out;
  logic [31:0] red_linear_out;
  logic [31:0] green_linear_out;
  logic [31:0] blue_linear_out;
  logic [31:0] alpha_linear_out;

  modport source (
    output valid, byte_address, red_byte_out, green_byte_out, blue_byte_out, alpha_byte_out,
           red_linear_out, green_linear_out, blue_linear_out, alpha_linear_out,
    input  ready
  );
  modport sink (
    input  valid, byte_address, red_byte_out, green_byte_out, blue_byte_out, alpha_byte_out,
           red_linear_out, green_linear_out, blue_linear_out, alpha_linear_out,
    output ready
  );
endinterface

// ----- sv/srgb8_pixel_encode_decode.sv -----
// top level: config registers, lanes, merge into the output register
// an input item passes the lane and address registers, then the output register
// throughput: one item per cycle unless out_ch stalls; three colour lanes and an
// alpha lane run in parallel; 255-comparator stage, then count stage, per colour lane
// reset: has_alpha 1, width 1, height 1, pipeline empty; tables are constants
module srgb8_pixel_encode_decode #(
  parameter int unsigned MAX_WIDTH  = srgb8_pkg::SRGB8_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = srgb8_pkg::SRGB8_MAX_HEIGHT,
  parameter int unsigned MAX_DEPTH  = srgb8_pkg::SRGB8_MAX_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srgb8_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [srgb8_pkg::CFG_W-1:0]   cfg_data_i,
  srgb8_in_if.sink                      in_ch,
  srgb8_out_if.source                   out_ch
);
  import srgb8_pkg::*;

  logic              has_alpha_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [DIM_W-1:0]  width_d;
  logic [DIM_W-1:0]  height_d;
  logic [2*DIM_W-1:0] wh_q;
  logic              en;
  logic              v1_q;
  logic              v2_q;
  lane_ctrl_t        ctrl;
  logic [7:0]        r_b, g_b, b_b, a_b;
  logic [31:0]       r_l, g_l, b_l, a_l;
  logic [ADDR_W-1:0] addr;

  // clamp written dimensions to 1..max
  always_comb begin
    width_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      width_d = DIM_W'(1);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      width_d = DIM_W'(MAX_WIDTH);
    end
    height_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      height_d = DIM_W'(1);
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      height_d = DIM_W'(MAX_HEIGHT);
    end
  end

  // configuration registers, slice size kept alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_alpha_q <= 1'b1;
      width_q     <= DIM_W'(1);
      height_q    <= DIM_W'(1);
      wh_q        <= (2*DIM_W)'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HAS_ALPHA:    has_alpha_q <= cfg_data_i[0];
        REG_IMAGE_WIDTH: begin
          width_q <= width_d;
          wh_q    <= (2*DIM_W)'(width_d) * (2*DIM_W)'(height_q);
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= height_d;
          wh_q     <= (2*DIM_W)'(width_q) * (2*DIM_W)'(height_d);
        end
        default:          ;
      endcase
    end
  end

  // pipeline moves as one while the output register is free or draining
  assign en          = !v2_q || out_ch.ready;
  assign in_ch.ready = en;
  assign ctrl.en     = en;
  assign ctrl.cmd    = in_ch.command;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_ch.valid;
      v2_q <= v1_q;
    end
  end

  // lanes
  srgb8_color_lane u_red (
    .clk_i, .ctrl_i(ctrl), .lin_i(in_ch.red_linear), .srgb_i(in_ch.red_srgb),
    .byte_o(r_b), .lin_o(r_l)
  );
  srgb8_color_lane u_green (
    .clk_i, .ctrl_i(ctrl), .lin_i(in_ch.green_linear), .srgb_i(in_ch.green_srgb),
    .byte_o(g_b), .lin_o(g_l)
  );
  srgb8_color_lane u_blue (
    .clk_i, .ctrl_i(ctrl), .lin_i(in_ch.blue_linear), .srgb_i(in_ch.blue_srgb),
    .byte_o(b_b), .lin_o(b_l)
  );
  srgb8_alpha_lane u_alpha (
    .clk_i, .ctrl_i(ctrl), .has_alpha_i(has_alpha_q), .lin_i(in_ch.alpha_linear),
    .byte_i(in_ch.alpha_byte), .byte_o(a_b), .lin_o(a_l)
  );
  srgb8_addr_unit #(.MAX_DEPTH(MAX_DEPTH)) u_addr (
    .clk_i, .en_i(en), .has_alpha_i(has_alpha_q), .width_i(width_q), .slice_size_i(wh_q),
    .x_i(in_ch.pos_x), .y_i(in_ch.pos_y), .z_i(in_ch.pos_z), .addr_o(addr)
  );

  // merge into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ch.byte_address     <= addr;
      out_ch.red_byte_out     <= r_b;
      out_ch.green_byte_out   <= g_b;
      out_ch.blue_byte_out    <= b_b;
      out_ch.alpha_byte_out   <= a_b;
      out_ch.red_linear_out   <= r_l;
      out_ch.green_linear_out <= g_l;
      out_ch.blue_linear_out  <= b_l;
      out_ch.alpha_linear_out <= a_l;
    end
  end

  assign out_ch.valid = v2_q;

endmodule

// ----- sv/srgb8_color_lane.sv -----
// one colour channel lane: threshold compare encode and table decode
module srgb8_color_lane (
  input  logic                   clk_i,
  input  srgb8_pkg::lane_ctrl_t  ctrl_i,
  input  logic [31:0]            lin_i,
  input  logic [7:0]             srgb_i,
  output logic [7:0]             byte_o,
  output logic [31:0]            lin_o
);
  import srgb8_pkg::*;

  logic [255:0] ge;
  logic [255:0] therm_q;
  logic [31:0]  lin_rom [256];
  logic [31:0]  dec_q;
  logic         cmd_q;
  logic         bad;
  logic [7:0]   idx;
  logic [7:0]   cand;

  // NaN, infinity and any sign give zero
  assign bad   = lin_i[31] || (lin_i[30:23] == 8'hFF);
  assign ge[0] = 1'b1;

  // one comparator per rounding threshold
  for (genvar k = 1; k < 256; k++) begin : g_thr
    localparam logic [31:0] TK = srgb8_f32_bits(srgb8_thresh(k), 1'b1);
    assign ge[k] = !bad && (lin_i[30:0] >= TK[30:0]);
  end

  // decode table
  for (genvar i = 0; i < 256; i++) begin : g_rom
    localparam logic [31:0] LK = srgb8_f32_bits(LIN_TAB[i], 1'b0);
    assign lin_rom[i] = LK;
  end

  // compare stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      therm_q <= ge;
      dec_q   <= lin_rom[srgb_i];
      cmd_q   <= ctrl_i.cmd;
    end
  end

  // thermometer count by binary search
  always_comb begin
    idx  = 8'd0;
    cand = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      cand = idx | (8'd1 << b);
      if (therm_q[cand]) begin
        idx = cand;
      end
    end
  end

  assign byte_o = (cmd_q == CMD_ENCODE) ? idx : 8'd0;
  assign lin_o  = (cmd_q == CMD_DECODE) ? dec_q : 32'd0;

endmodule

// ----- sv/srgb8_alpha_lane.sv -----
// alpha lane: floor(a*255) encode with float rounding, byte/255 decode
module srgb8_alpha_lane (
  input  logic                   clk_i,
  input  srgb8_pkg::lane_ctrl_t  ctrl_i,
  input  logic                   has_alpha_i,
  input  logic [31:0]            lin_i,
  input  logic [7:0]             byte_i,
  output logic [7:0]             byte_o,
  output logic [31:0]            lin_o
);
  import srgb8_pkg::*;

  logic [31:0] div_rom [256];
  logic [23:0] mant;
  logic [31:0] prod_q;
  logic [7:0]  exp_q;
  logic        sign_q;
  logic        frac_nz_q;
  logic [31:0] dec_q;
  logic        cmd_q;
  logic [23:0] kept;
  logic        guard;
  logic        sticky;
  logic [24:0] rnd;
  logic [32:0] val;
  logic [7:0]  sh;
  logic [32:0] q;
  logic [7:0]  enc;

  // decode table, byte over 255
  for (genvar i = 0; i < 256; i++) begin : g_rom
    localparam logic [31:0] DK = srgb8_f32_bits(real'(i) / 255.0, 1'b0);
    assign div_rom[i] = DK;
  end

  assign mant = {(lin_i[30:23] != 8'd0), lin_i[22:0]};

  // multiply stage: mant*255 is exact in 32 bits
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q    <= {mant, 8'd0} - {8'd0, mant};
      exp_q     <= lin_i[30:23];
      sign_q    <= lin_i[31];
      frac_nz_q <= (lin_i[22:0] != 23'd0);
      dec_q     <= div_rom[byte_i];
      cmd_q     <= ctrl_i.cmd;
    end
  end

  // round product to 24 bits, then floor and saturate
  always_comb begin
    if (prod_q[31]) begin
      kept   = prod_q[31:8];
      guard  = prod_q[7];
      sticky = (prod_q[6:0] != 7'd0);
    end else begin
      kept   = prod_q[30:7];
      guard  = prod_q[6];
      sticky = (prod_q[5:0] != 6'd0);
    end
    rnd = {1'b0, kept} + {24'd0, guard && (sticky || kept[0])};
    val = prod_q[31] ? {rnd, 8'd0} : {1'b0, rnd, 7'd0};
    sh  = 8'd150 - exp_q;
    q   = (sh >= 8'd33) ? 33'd0 : (val >> sh);
    if (sign_q || exp_q == 8'd0) begin
      enc = 8'd0;
    end else if (exp_q == 8'hFF) begin
      enc = frac_nz_q ? 8'd0 : 8'd255;
    end else if (exp_q >= 8'd150 || q >= 33'd255) begin
      enc = 8'd255;
    end else begin
      enc = q[7:0];
    end
  end

  assign byte_o = (cmd_q == CMD_ENCODE && has_alpha_i) ? enc : 8'd0;
  assign lin_o  = (cmd_q == CMD_ENCODE) ? 32'd0 : (has_alpha_i ? dec_q : F32_ONE);

endmodule

// ----- sv/srgb8_addr_unit.sv -----
// byte address of a pixel: (w*h*z + w*y + x) * bytes per pixel
module srgb8_addr_unit #(
  parameter int unsigned MAX_DEPTH = srgb8_pkg::SRGB8_MAX_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic                              has_alpha_i,
  input  logic [srgb8_pkg::DIM_W-1:0]       width_i,
  input  logic [2*srgb8_pkg::DIM_W-1:0]     slice_size_i,
  input  logic [srgb8_pkg::POS_W-1:0]       x_i,
  input  logic [srgb8_pkg::POS_W-1:0]       y_i,
  input  logic [srgb8_pkg::Z_W-1:0]         z_i,
  output logic [srgb8_pkg::ADDR_W-1:0]      addr_o
);
  import srgb8_pkg::*;

  localparam int unsigned ZMAX = MAX_DEPTH - 1;

  logic [Z_W-1:0]           z_sat;
  logic [ADDR_W-1:0]        slice_q;
  logic [DIM_W+POS_W-1:0]   row_q;
  logic [POS_W-1:0]         x_q;
  logic [ADDR_W-1:0]        base;

  assign z_sat = (32'(z_i) > ZMAX) ? Z_W'(ZMAX) : z_i;

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slice_q <= ADDR_W'(slice_size_i) * ADDR_W'(z_sat);
      row_q   <= (DIM_W+POS_W)'(width_i) * (DIM_W+POS_W)'(y_i);
      x_q     <= x_i;
    end
  end

  // sum and scale by three or four bytes
  assign base   = slice_q + ADDR_W'(row_q) + ADDR_W'(x_q);
  assign addr_o = has_alpha_i ? (base << 2) : (base + (base << 1));

endmodule

// ----- sv/srgb8_checker.sv -----
// port-level checks on the converter, bound to the top level
module srgb8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [33:0] addr,
  input logic [7:0]  rb,
  input logic [7:0]  gb,
  input logic [7:0]  bb,
  input logic [7:0]  ab,
  input logic [31:0] rl,
  input logic [31:0] al
);

  // a stalled item stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result item dropped while stalled");

  // a stalled item keeps its address
  a_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(addr)) else $error("result changed while stalled");

  // an encode item carries no linear colour
  a_enc_no_lin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (rb != 8'd0) |-> (rl == 32'd0) && (al == 32'd0))
    else $error("encode item with linear fields set");

  // a decode item carries no bytes
  a_dec_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (rl != 32'd0) |-> (rb == 8'd0) && (gb == 8'd0) && (bb == 8'd0) && (ab == 8'd0))
    else $error("decode item with byte fields set");

endmodule

bind srgb8_pixel_encode_decode srgb8_checker u_srgb8_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .addr      (out_ch.byte_address),
  .rb        (out_ch.red_byte_out),
  .gb        (out_ch.green_byte_out),
  .bb        (out_ch.blue_byte_out),
  .ab        (out_ch.alpha_byte_out),
  .rl        (out_ch.red_linear_out),
  .al        (out_ch.alpha_linear_out)
);

// ----- verif/tb_top.sv -----
// self-checking testbench for the srgb8 pixel encode/decode block
`timescale 1ns / 1ps

module tb_top;
  import srgb8_pkg::*;

  // one pixel item as offered to the block
  typedef struct {
    cmd_e        cmd;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  z;
    logic [31:0] lin [4];
    logic [7:0]  srgb [4];
  } pixel_t;

  // one predicted result item
  typedef struct {
    logic [33:0] addr;
    logic [7:0]  byte_o [4];
    logic [31:0] lin_o [4];
  } pixel_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_idx = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  srgb8_in_if  in_ch ();
  srgb8_out_if out_ch ();

  srgb8_pixel_encode_decode i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // predictor copy of the registers
  logic        cur_alpha;
  int unsigned cur_width;
  int unsigned cur_height;
  real         enc_edge [256];

  pixel_res_t  pending_pixels [$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_encode = 0;
  int unsigned n_decode = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold = 1'b0;

  always #2 clk_i = ~clk_i;

  // float32 bits to an exact double
  function automatic real f32_value(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'd0) begin
      v = real'(f[22:0]) / (2.0 ** 149);
    end else begin
      v = $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0});
    end
    return f[31] ? -((f[30:23] == 8'd0) ? v : -v) * 1.0 : v;
  endfunction

  // positive normal double (or zero) to nearest-even float32 bits
  function automatic logic [31:0] f32_nearest(input real q);
    logic [63:0] d;
    logic        bump;
    if (q == 0.0) begin
      return 32'd0;
    end
    d    = $realtobits(q);
    bump = d[28] && ((d[27:0] != 28'd0) || d[29]);
    return {1'b0, 8'(d[62:52] - 11'd896), d[51:29]} + {31'd0, bump};
  endfunction

  // newton fifth root for the threshold derivation below
  function automatic real root5(input real a);
    real y;
    real y4;
    y = 1.0;
    for (int i = 0; i < 80; i++) begin
      y4 = y * y * y * y;
      y  = (4.0 * y + a / y4) / 5.0;
    end
    return y;
  endfunction

  // linear value at which the rounded sRGB byte steps to k
  task automatic build_edges();
    real s;
    real t;
    real b;
    for (int k = 1; k <= 255; k++) begin
      s = (real'(k) - 0.5) / 255.0;
      t = s / 12.92;
      if (t >= 0.0031308) begin
        b = (s + 0.055) / 1.055;
        t = b * b * root5(b * b);
      end
      enc_edge[k] = t;
    end
  endtask

  // colour channel to sRGB byte by counting edges passed
  function automatic logic [7:0] srgb_of(input logic [31:0] f);
    real v;
    int  n;
    if (f[30:23] == 8'hFF) begin
      return 8'd0;
    end
    v = f32_value(f);
    n = 0;
    for (int k = 1; k <= 255; k++) begin
      if (v >= enc_edge[k]) n++;
    end
    return 8'(n);
  endfunction

  // alpha to byte: float product with 255, floored and saturated
  function automatic logic [7:0] alpha_byte_of(input logic [31:0] f);
    real q;
    real r;
    int  n;
    if (f[30:23] == 8'hFF) begin
      return (f[22:0] == 23'd0 && !f[31]) ? 8'd255 : 8'd0;
    end
    if (f[31] || f[30:0] == 31'd0) begin
      return 8'd0;
    end
    q = f32_value(f) * 255.0;
    if (q >= 255.0) begin
      return 8'd255;
    end
    if (q < 2.0 ** -126) begin
      return 8'd0;
    end
    r = f32_value(f32_nearest(q));
    if (r >= 255.0) begin
      return 8'd255;
    end
    n = int'(r);
    if (real'(n) > r) n--;
    return 8'(n);
  endfunction

  // expected result item for one pixel under the current registers
  function automatic pixel_res_t convert_pixel(input pixel_t p);
    pixel_res_t  r;
    logic [63:0] a;
    a = (64'(cur_width) * 64'(cur_height) * 64'(p.z) + 64'(cur_width) * 64'(p.y)
         + 64'(p.x)) * (cur_alpha ? 64'd4 : 64'd3);
    r.addr = a[33:0];
    for (int c = 0; c < 4; c++) begin
      r.byte_o[c] = 8'd0;
      r.lin_o[c]  = 32'd0;
    end
    if (p.cmd == CMD_ENCODE) begin
      for (int c = 0; c < 3; c++) r.byte_o[c] = srgb_of(p.lin[c]);
      r.byte_o[3] = cur_alpha ? alpha_byte_of(p.lin[3]) : 8'd0;
    end else begin
      for (int c = 0; c < 3; c++) r.lin_o[c] = f32_nearest(LIN_TAB[p.srgb[c]]);
      r.lin_o[3] = cur_alpha ? f32_nearest(real'(p.srgb[3]) / 255.0) : F32_ONE;
    end
    return r;
  endfunction

  // register write at a falling edge, mirrored into the predictor
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    int unsigned v;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    v = (val == 0) ? 1 : int'(val);
    case (idx)
      REG_HAS_ALPHA:    cur_alpha = val[0];
      REG_IMAGE_WIDTH:  cur_width = (v > SRGB8_MAX_WIDTH) ? SRGB8_MAX_WIDTH : v;
      REG_IMAGE_HEIGHT: cur_height = (v > SRGB8_MAX_HEIGHT) ? SRGB8_MAX_HEIGHT : v;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // offer one item, with random idle cycles first; returns at a falling edge
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= p.cmd;
    in_ch.pos_x        <= p.x;
    in_ch.pos_y        <= p.y;
    in_ch.pos_z        <= p.z;
    in_ch.red_linear   <= p.lin[0];
    in_ch.green_linear <= p.lin[1];
    in_ch.blue_linear  <= p.lin[2];
    in_ch.alpha_linear <= p.lin[3];
    in_ch.red_srgb     <= p.srgb[0];
    in_ch.green_srgb   <= p.srgb[1];
    in_ch.blue_srgb    <= p.srgb[2];
    in_ch.alpha_byte   <= p.srgb[3];
    do @(posedge clk_i); while (!in_ch.ready);
    pending_pixels.push_back(convert_pixel(p));
    n_sent++;
    if (p.cmd == CMD_ENCODE) n_encode++; else n_decode++;
    @(negedge clk_i);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // random float32 pattern, weighted towards the interesting ranges
  function automatic logic [31:0] rand_f32(input bit for_alpha);
    logic [31:0] f;
    int unsigned sel;
    sel = $urandom_range(11);
    f = $urandom;
    case (sel)
      0, 1, 2, 3: f = {1'b0, 8'($urandom_range(100, 126)), f[22:0]};
      4:          f = {1'b0, 8'($urandom_range(112, 119)), f[22:0]};
      5:          f = 32'h3F80_0000 + 32'($urandom_range(8)) - 32'd4;
      6:          f = {1'b0, 8'd0, f[22:0]};
      7:          f = {1'b1, 8'($urandom_range(100, 130)), f[22:0]};
      8:          f = {f[31], 8'hFF, ($urandom_range(1) != 0) ? 23'd0 : f[22:0]};
      9:          f = for_alpha ? f32_nearest(real'($urandom_range(1, 254)) / 255.0)
                                  + 32'($urandom_range(2)) - 32'd1
                                : {1'b0, 8'($urandom_range(127, 140)), f[22:0]};
      default: ;
    endcase
    return f;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.cmd = ($urandom_range(1) != 0) ? CMD_DECODE : CMD_ENCODE;
    p.x   = 12'($urandom);
    p.y   = 12'($urandom);
    p.z   = 8'($urandom);
    for (int c = 0; c < 4; c++) begin
      p.lin[c]  = rand_f32(c == 3);
      p.srgb[c] = 8'($urandom);
    end
    return p;
  endfunction

  // one encode item with the given channel patterns
  function automatic pixel_t enc_pixel(input logic [31:0] c, input logic [31:0] a);
    pixel_t p;
    p = rand_pixel();
    p.cmd = CMD_ENCODE;
    for (int i = 0; i < 3; i++) p.lin[i] = c;
    p.lin[3] = a;
    return p;
  endfunction

  // directed: field extremes and every special value
  task automatic test_directed();
    pixel_t p;
    logic [31:0] specials [16] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0001, 32'h3F7F_FFFF,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hBF00_0000, 32'h0000_0001,
      32'h3B4D_2E1C, 32'h3B4D_2E1B, 32'h3F00_0000, 32'h7F7F_FFFF, 32'h3B80_8081,
      32'hFFFF_FFFF};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_IMAGE_WIDTH, 13'd4096);
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    for (int i = 0; i < 16; i++) begin
      send_pixel(enc_pixel(specials[i], specials[15 - i]));
    end
    // decode corners with maximum position, which gives the largest address
    for (int i = 0; i < 4; i++) begin
      p = rand_pixel();
      p.cmd = CMD_DECODE;
      p.x = 12'hFFF;
      p.y = 12'hFFF;
      p.z = 8'hFF;
      for (int c = 0; c < 4; c++) p.srgb[c] = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'(i);
      send_pixel(p);
    end
    drain();
    // no alpha channel: encode and decode once each
    write_reg(REG_HAS_ALPHA, 1'b0);
    send_pixel(enc_pixel(32'h3F00_0000, 32'h3F80_0000));
    p = rand_pixel();
    p.cmd = CMD_DECODE;
    send_pixel(p);
    drain();
  endtask

  // random items under one register setting and idling mix
  task automatic test_random(input int unsigned count, input int unsigned s_idle,
                             input int unsigned r_idle, input logic alpha,
                             input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_HAS_ALPHA, alpha);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) send_pixel(rand_pixel());
    drain();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_UNUSED, 13'h1FFF);
    fork
      begin
        recv_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join_none
    repeat (60) send_pixel(rand_pixel());
    drain();
  endtask

  // receiver readiness, redrawn each cycle
  always @(negedge clk_i) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(input string name, input logic [33:0] exp_v,
                             input logic [33:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    pixel_res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected item, expected none, got address %h", $realtime,
                 out_ch.byte_address);
      end else begin
        e = pending_pixels.pop_front();
        n_checked++;
        check_field("byte_address", e.addr, out_ch.byte_address);
        check_field("red_byte_out", 34'(e.byte_o[0]), 34'(out_ch.red_byte_out));
        check_field("green_byte_out", 34'(e.byte_o[1]), 34'(out_ch.green_byte_out));
        check_field("blue_byte_out", 34'(e.byte_o[2]), 34'(out_ch.blue_byte_out));
        check_field("alpha_byte_out", 34'(e.byte_o[3]), 34'(out_ch.alpha_byte_out));
        check_field("red_linear_out", 34'(e.lin_o[0]), 34'(out_ch.red_linear_out));
        check_field("green_linear_out", 34'(e.lin_o[1]), 34'(out_ch.green_linear_out));
        check_field("blue_linear_out", 34'(e.lin_o[2]), 34'(out_ch.blue_linear_out));
        check_field("alpha_linear_out", 34'(e.lin_o[3]), 34'(out_ch.alpha_linear_out));
      end
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_ENCODE;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pos_z        = '0;
    in_ch.red_linear   = '0;
    in_ch.green_linear = '0;
    in_ch.blue_linear  = '0;
    in_ch.alpha_linear = '0;
    in_ch.red_srgb     = '0;
    in_ch.green_srgb   = '0;
    in_ch.blue_srgb    = '0;
    in_ch.alpha_byte   = '0;
    out_ch.ready       = 1'b0;
    cur_alpha  = 1'b1;
    cur_width  = 1;
    cur_height = 1;
    build_edges();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(450, 13, 79, 1'b1, 13'd4096, 13'd4096);
    test_random(450, 79, 13, 1'b0, 13'(1 + $urandom_range(4095)), 13'(1 + $urandom_range(4095)));
    test_random(450, 0, 0, 1'b1, 13'd0, 13'd0);
    test_random(40, 0, 0, 1'b0, 13'd8191, 13'd1);
    test_backpressure();

    $display("%0d items sent (%0d encode, %0d decode), %0d results checked", n_sent,
             n_encode, n_decode, n_checked);
    $display("covered special floats, both pixel sizes, extreme image sizes, long stall");
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
